### hdl/assignment_branch_and_bound_assert.svh
`ifndef ASSIGNMENT_BRANCH_AND_BOUND_ASSERT_SVH
`define ASSIGNMENT_BRANCH_AND_BOUND_ASSERT_SVH

// clocked assertion, off during reset
`define ABB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// clocked assertion, also checked while reset is low
`define ABB_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### hdl/abb_pkg.sv
package abb_pkg;
  localparam int MAX_JOBS = 8;
  localparam int IDX_W    = 3;
  localparam int CNT_W    = 4;
  localparam int COST_W   = 16;
  localparam int ACC_W    = 20;
  localparam int ADDR_W   = 6;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] n;
  } abb_ctrl_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [ACC_W-1:0] best_cost;
  } abb_stat_t;
endpackage

### hdl/abb_alu.sv
module abb_alu (
  input  logic [abb_pkg::ACC_W-1:0] a_i,
  input  logic [abb_pkg::ACC_W-1:0] b_i,
  output logic [abb_pkg::ACC_W-1:0] sum_o,
  output logic                      lt_o
);
  import abb_pkg::*;

  assign sum_o = a_i + b_i;
  assign lt_o  = (a_i < b_i);
endmodule

### hdl/abb_search.sv
module abb_search (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  abb_pkg::abb_ctrl_t         ctrl_i,
  output abb_pkg::abb_stat_t         stat_o,
  input  logic                       wr_en_i,
  input  logic [abb_pkg::ADDR_W-1:0] wr_addr_i,
  input  logic [abb_pkg::COST_W-1:0] wr_data_i,
  input  logic [abb_pkg::IDX_W-1:0]  idx_i,
  output logic [abb_pkg::IDX_W-1:0]  job_o
);
  import abb_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_ENTER, S_BJ, S_BJ_C, S_P_CHK, S_J_SCAN, S_J_CMP,
    S_PK_INIT, S_PK_SCAN, S_PK_CMP, S_PK_DONE, S_DESC, S_LEAF, S_DONE
  } state_e;

  state_e                  state_q;
  logic [IDX_W-1:0]        lvl_q;
  logic [CNT_W-1:0]        n_q, bj_q, p_q, jj_q, kj_q;
  logic [ACC_W-1:0]        acc_q, mn_q, selb_q, bestc_q;
  logic                    found_q, have_q;
  logic [IDX_W-1:0]        selj_q;
  logic [MAX_JOBS-1:0]     taken_q;
  logic [MAX_JOBS-1:0]     tried_q [MAX_JOBS];
  logic [ACC_W-1:0]        sofar_q [MAX_JOBS];
  logic [IDX_W-1:0]        trial_q [MAX_JOBS];
  logic [IDX_W-1:0]        best_q  [MAX_JOBS];

  logic [COST_W-1:0]       cost_mem [MAX_JOBS*MAX_JOBS];
  logic [ACC_W-1:0]        bnd_mem  [MAX_JOBS*MAX_JOBS];
  logic [COST_W-1:0]       cm_rdata_q;
  logic [ACC_W-1:0]        bd_rdata_q;
  logic [ADDR_W-1:0]       cm_raddr, bd_addr_rd, bd_addr_wr;
  logic                    bd_we;

  logic [ACC_W-1:0]        alu_a, alu_b, alu_sum;
  logic                    alu_lt;
  logic [CNT_W-1:0]        lvl_next;
  logic [ACC_W-1:0]        cm_ext;

  assign lvl_next = {1'b0, lvl_q} + 4'd1;
  assign cm_ext   = {{(ACC_W-COST_W){1'b0}}, cm_rdata_q};

  always_comb begin
    case (state_q)
      S_J_SCAN:  cm_raddr = {p_q[IDX_W-1:0], jj_q[IDX_W-1:0]};
      S_PK_DONE: cm_raddr = {lvl_q, selj_q};
      default:   cm_raddr = {lvl_q, bj_q[IDX_W-1:0]};
    endcase
  end

  assign bd_addr_rd = {lvl_q, kj_q[IDX_W-1:0]};
  assign bd_addr_wr = {lvl_q, bj_q[IDX_W-1:0]};
  assign bd_we      = (state_q == S_P_CHK) && (p_q >= n_q);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      cost_mem[wr_addr_i] <= wr_data_i;
    end
    cm_rdata_q <= cost_mem[cm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bd_we) begin
      bnd_mem[bd_addr_wr] <= acc_q;
    end
    bd_rdata_q <= bnd_mem[bd_addr_rd];
  end

  always_comb begin
    case (state_q)
      S_BJ_C:    begin alu_a = acc_q;         alu_b = cm_ext;  end
      S_J_CMP:   begin alu_a = cm_ext;        alu_b = mn_q;    end
      S_PK_CMP:  begin alu_a = bd_rdata_q;    alu_b = selb_q;  end
      S_PK_DONE: begin alu_a = bestc_q;       alu_b = selb_q;  end
      S_DESC:    begin alu_a = sofar_q[lvl_q]; alu_b = cm_ext; end
      S_LEAF:    begin alu_a = acc_q;         alu_b = bestc_q; end
      default:   begin alu_a = acc_q;         alu_b = mn_q;    end
    endcase
  end

  abb_alu u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .sum_o (alu_sum),
    .lt_o  (alu_lt)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= '0;
      n_q     <= CNT_W'(MAX_JOBS);
      bj_q    <= '0;
      p_q     <= '0;
      jj_q    <= '0;
      kj_q    <= '0;
      acc_q   <= '0;
      mn_q    <= '0;
      selb_q  <= '0;
      bestc_q <= '1;
      found_q <= 1'b0;
      have_q  <= 1'b0;
      selj_q  <= '0;
      taken_q <= '0;
      for (int i = 0; i < MAX_JOBS; i++) begin
        tried_q[i] <= '0;
        sofar_q[i] <= '0;
        trial_q[i] <= '0;
        best_q[i]  <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (ctrl_i.start) begin
            n_q        <= ctrl_i.n;
            lvl_q      <= '0;
            taken_q    <= '0;
            bestc_q    <= '1;
            sofar_q[0] <= '0;
            state_q    <= S_ENTER;
          end
        end
        S_ENTER: begin
          tried_q[lvl_q] <= '0;
          bj_q           <= '0;
          state_q        <= S_BJ;
        end
        S_BJ: begin
          if (bj_q == n_q) begin
            state_q <= S_PK_INIT;
          end else if (taken_q[bj_q[IDX_W-1:0]]) begin
            bj_q <= bj_q + 4'd1;
          end else begin
            acc_q   <= sofar_q[lvl_q];
            state_q <= S_BJ_C;
          end
        end
        S_BJ_C: begin
          acc_q   <= alu_sum;
          p_q     <= lvl_next;
          state_q <= S_P_CHK;
        end
        S_P_CHK: begin
          if (p_q >= n_q) begin
            bj_q    <= bj_q + 4'd1;
            state_q <= S_BJ;
          end else begin
            jj_q    <= '0;
            found_q <= 1'b0;
            mn_q    <= '0;
            state_q <= S_J_SCAN;
          end
        end
        S_J_SCAN: begin
          if (jj_q == n_q) begin
            if (found_q) begin
              acc_q <= alu_sum;
            end
            p_q     <= p_q + 4'd1;
            state_q <= S_P_CHK;
          end else if (taken_q[jj_q[IDX_W-1:0]] || (jj_q == bj_q)) begin
            jj_q <= jj_q + 4'd1;
          end else begin
            state_q <= S_J_CMP;
          end
        end
        S_J_CMP: begin
          if (!found_q || alu_lt) begin
            mn_q    <= cm_ext;
            found_q <= 1'b1;
          end
          jj_q    <= jj_q + 4'd1;
          state_q <= S_J_SCAN;
        end
        S_PK_INIT: begin
          kj_q    <= '0;
          have_q  <= 1'b0;
          state_q <= S_PK_SCAN;
        end
        S_PK_SCAN: begin
          if (kj_q == n_q) begin
            state_q <= S_PK_DONE;
          end else if (taken_q[kj_q[IDX_W-1:0]] || tried_q[lvl_q][kj_q[IDX_W-1:0]]) begin
            kj_q <= kj_q + 4'd1;
          end else begin
            state_q <= S_PK_CMP;
          end
        end
        S_PK_CMP: begin
          if (!have_q || alu_lt) begin
            selb_q <= bd_rdata_q;
            selj_q <= kj_q[IDX_W-1:0];
            have_q <= 1'b1;
          end
          kj_q    <= kj_q + 4'd1;
          state_q <= S_PK_SCAN;
        end
        S_PK_DONE: begin
          // bounds come in ascending order, so the first pruned one ends the level
          if (!have_q || alu_lt) begin
            if (lvl_q == '0) begin
              state_q <= S_DONE;
            end else begin
              lvl_q                         <= lvl_q - 3'd1;
              taken_q[trial_q[lvl_q - 3'd1]] <= 1'b0;
              state_q                       <= S_PK_INIT;
            end
          end else begin
            tried_q[lvl_q][selj_q] <= 1'b1;
            taken_q[selj_q]        <= 1'b1;
            trial_q[lvl_q]         <= selj_q;
            state_q                <= S_DESC;
          end
        end
        S_DESC: begin
          if (lvl_next == n_q) begin
            acc_q   <= alu_sum;
            state_q <= S_LEAF;
          end else begin
            sofar_q[lvl_next[IDX_W-1:0]] <= alu_sum;
            lvl_q                        <= lvl_next[IDX_W-1:0];
            state_q                      <= S_ENTER;
          end
        end
        S_LEAF: begin
          if (alu_lt) begin
            bestc_q <= acc_q;
            for (int i = 0; i < MAX_JOBS; i++) begin
              best_q[i] <= trial_q[i];
            end
          end
          taken_q[trial_q[lvl_q]] <= 1'b0;
          state_q                 <= S_PK_INIT;
        end
        S_DONE: begin
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign stat_o.busy      = (state_q != S_IDLE);
  assign stat_o.done      = (state_q == S_DONE);
  assign stat_o.best_cost = bestc_q;
  assign job_o            = best_q[idx_i];
endmodule

### hdl/assignment_branch_and_bound.sv
// Load: one cost word accepted per cycle while in_stall_o is low, n*n words per matrix.
// Solve: depth-first search on one shared add/compare unit; roughly n^3
// cost-memory reads per search node, data dependent.
// Results: n words, one per cycle while not stalled; no input taken meanwhile.
// Reset (async, active low): side 8, load restarts, no result pending.
module assignment_branch_and_bound (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_wr_en_i,
  input  logic [abb_pkg::CNT_W-1:0]  cfg_wr_data_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [abb_pkg::COST_W-1:0] cost_entry_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 person_index_o,
  output logic [2:0]                 assigned_job_o,
  output logic [18:0]                total_cost_o,
  output logic                       last_of_run_o
);
  import abb_pkg::*;

  typedef enum logic [1:0] {T_LOAD, T_SOLVE, T_EMIT} top_e;

  top_e               st_q;
  logic [CNT_W-1:0]   jobs_q, n_eff, n_m1;
  logic [IDX_W-1:0]   row_q, col_q, look_idx, job_w;
  logic               in_acc, last_entry;
  abb_ctrl_t          ctrl;
  abb_stat_t          stat;

  assign n_eff = (jobs_q == '0) ? 4'd1 :
                 (jobs_q > CNT_W'(MAX_JOBS)) ? CNT_W'(MAX_JOBS) : jobs_q;
  assign n_m1  = n_eff - 4'd1;

  assign in_stall_o = (st_q != T_LOAD);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign last_entry = ({1'b0, row_q} == n_m1) && ({1'b0, col_q} == n_m1);

  assign ctrl.start = in_acc && last_entry;
  assign ctrl.n     = n_eff;
  assign look_idx   = (st_q == T_EMIT) ? person_index_o + 3'd1 : '0;

  abb_search u_search (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .stat_o    (stat),
    .wr_en_i   (in_acc),
    .wr_addr_i ({row_q, col_q}),
    .wr_data_i (cost_entry_i),
    .idx_i     (look_idx),
    .job_o     (job_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q           <= T_LOAD;
      jobs_q         <= CNT_W'(MAX_JOBS);
      row_q          <= '0;
      col_q          <= '0;
      out_valid_o    <= 1'b0;
      person_index_o <= '0;
      assigned_job_o <= '0;
      total_cost_o   <= '0;
      last_of_run_o  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        jobs_q <= cfg_wr_data_i;
        row_q  <= '0;
        col_q  <= '0;
      end
      case (st_q)
        T_LOAD: begin
          if (in_acc && !cfg_wr_en_i) begin
            if ({1'b0, col_q} == n_m1) begin
              col_q <= '0;
              row_q <= last_entry ? '0 : row_q + 3'd1;
            end else begin
              col_q <= col_q + 3'd1;
            end
            if (last_entry) begin
              st_q <= T_SOLVE;
            end
          end
        end
        T_SOLVE: begin
          if (stat.done) begin
            out_valid_o    <= 1'b1;
            person_index_o <= '0;
            assigned_job_o <= job_w;
            total_cost_o   <= stat.best_cost[18:0];
            last_of_run_o  <= (n_eff == 4'd1);
            st_q           <= T_EMIT;
          end
        end
        T_EMIT: begin
          if (out_valid_o && !out_stall_i) begin
            if (last_of_run_o) begin
              out_valid_o <= 1'b0;
              st_q        <= T_LOAD;
            end else begin
              person_index_o <= look_idx;
              assigned_job_o <= job_w;
              last_of_run_o  <= (({1'b0, person_index_o} + 4'd2) == n_eff);
            end
          end
        end
        default: begin
          st_q <= T_LOAD;
        end
      endcase
    end
  end
endmodule

### hdl/abb_checker.sv
`include "assignment_branch_and_bound_assert.svh"

module abb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [2:0]  person_index_o,
  input logic [2:0]  assigned_job_o,
  input logic [18:0] total_cost_o,
  input logic        last_of_run_o
);
  `ABB_ASSERT_RST(a_rst_no_word, (!rst_ni |-> !out_valid_o), "result word during reset")

  `ABB_ASSERT(a_busy_emit, (out_valid_o |-> in_stall_o), "input open while results pending")

  `ABB_ASSERT(a_hold, (out_valid_o && out_stall_i |=> out_valid_o && $stable(person_index_o) && $stable(assigned_job_o) && $stable(total_cost_o)), "stalled word changed")

  `ABB_ASSERT(a_next_person, (out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o && (person_index_o == $past(person_index_o) + 3'd1) && $stable(total_cost_o)), "person order broken")

  `ABB_ASSERT(a_run_end, (out_valid_o && !out_stall_i && last_of_run_o |=> !out_valid_o), "word after last of run")
endmodule

bind assignment_branch_and_bound abb_checker u_abb_checker (.*);

### dv/tb_assignment_branch_and_bound.sv
`timescale 1ns / 1ps

module tb_assignment_branch_and_bound;
  import abb_pkg::*;

  localparam int IDLE_LIMIT = 4000000;

  typedef struct {
    logic [2:0]  person;
    logic [2:0]  job;
    logic [18:0] total;
    logic        last;
  } assign_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_wr_en_i = 1'b0;
  logic [CNT_W-1:0]  cfg_wr_data_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [COST_W-1:0] cost_entry_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [2:0]        person_index_o;
  logic [2:0]        assigned_job_o;
  logic [18:0]       total_cost_o;
  logic              last_of_run_o;

  assignment_branch_and_bound dut (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .in_valid_i, .in_stall_o, .cost_entry_i,
    .out_valid_o, .out_stall_i,
    .person_index_o, .assigned_job_o, .total_cost_o, .last_of_run_o
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  assign_word_t expected_assign_q[$];

  // predictor state
  int unsigned side_cfg = 8;
  int unsigned loaded_entries = 0;
  longint unsigned costs [8][8];
  logic [7:0] taken_mask;
  longint unsigned best_total;
  int unsigned trial_job [8];
  int unsigned best_job [8];

  function automatic int unsigned matrix_side();
    if (side_cfg < 1) return 1;
    if (side_cfg > MAX_JOBS) return MAX_JOBS;
    return side_cfg;
  endfunction

  function automatic longint unsigned job_bound(int unsigned n, int unsigned lvl,
                                                int unsigned job, longint unsigned so_far);
    longint unsigned lb;
    longint unsigned mini;
    bit found;
    lb = so_far + costs[lvl][job];
    for (int unsigned p = lvl + 1; p < n; p++) begin
      mini = '1;
      found = 0;
      for (int unsigned j = 0; j < n; j++) begin
        if (!taken_mask[j] && j != job && costs[p][j] < mini) begin
          mini = costs[p][j];
          found = 1;
        end
      end
      if (found) lb += mini;
    end
    return lb;
  endfunction

  function automatic void explore_level(int unsigned n, int unsigned lvl,
                                        longint unsigned so_far);
    longint unsigned bnd [8];
    int unsigned jb [8];
    int unsigned count;
    int unsigned pos;
    longint unsigned b;
    count = 0;
    if (lvl >= n) begin
      if (best_total > so_far) begin
        best_total = so_far;
        best_job = trial_job;
      end
      return;
    end
    for (int unsigned j = 0; j < n; j++) begin
      if (!taken_mask[j]) begin
        b = job_bound(n, lvl, j, so_far);
        pos = count;
        while (pos > 0 && bnd[pos-1] > b) begin
          bnd[pos] = bnd[pos-1];
          jb[pos] = jb[pos-1];
          pos--;
        end
        bnd[pos] = b;
        jb[pos] = j;
        count++;
      end
    end
    for (int unsigned k = 0; k < count; k++) begin
      if (bnd[k] <= best_total) begin
        taken_mask[jb[k]] = 1'b1;
        trial_job[lvl] = jb[k];
        explore_level(n, lvl + 1, so_far + costs[lvl][jb[k]]);
        taken_mask[jb[k]] = 1'b0;
      end
    end
  endfunction

  function automatic void predict_cost_word(logic [COST_W-1:0] v);
    int unsigned n;
    assign_word_t w;
    n = matrix_side();
    if (loaded_entries >= n * n) loaded_entries = 0;
    costs[loaded_entries / n][loaded_entries % n] = v;
    loaded_entries++;
    if (loaded_entries < n * n) return;
    taken_mask = '0;
    best_total = '1;
    explore_level(n, 0, 0);
    for (int unsigned p = 0; p < n; p++) begin
      w.person = p[2:0];
      w.job = best_job[p][2:0];
      w.total = best_total[18:0];
      w.last = (p + 1 == n);
      expected_assign_q = {expected_assign_q, w};
    end
    loaded_entries = 0;
  endfunction

  // assumes entry at a falling edge; returns at a falling edge
  task automatic send_cost(input logic [COST_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cost_entry_i <= v;
    do @(posedge clk_i); while (in_stall_o);
    predict_cost_word(v);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    wait (expected_assign_q.size() == 0);
    repeat (40) @(negedge clk_i);
  endtask

  // side is only changed with nothing in flight
  task automatic write_side(input int unsigned v);
    wait_drained();
    cfg_wr_en_i <= 1'b1;
    cfg_wr_data_i <= v[CNT_W-1:0];
    @(negedge clk_i);
    cfg_wr_en_i <= 1'b0;
    side_cfg = v;
    loaded_entries = 0;
  endtask

  // kind 0: full range, 1: heavy ties, 2: all max
  task automatic send_matrix(input int unsigned n, input int unsigned kind);
    for (int unsigned i = 0; i < n * n; i++) begin
      case (kind)
        0: send_cost($urandom_range(65535));
        1: send_cost($urandom_range(3));
        default: send_cost(16'hffff);
      endcase
    end
  endtask

  task automatic test_directed();
    write_side(0);
    send_cost(16'h0000);
    send_cost(16'hffff);
    write_side(1);
    send_cost(16'h5a5a);
    write_side(2);
    send_matrix(2, 2);
    write_side(3);
    for (int unsigned i = 0; i < 9; i++) send_cost(16'h0007);
    wait_drained();
    // side change in the middle of a load restarts the matrix
    send_cost(16'h1234);
    send_cost(16'h4321);
    write_side(2);
    send_cost(16'h0001);
    send_cost(16'h0009);
    send_cost(16'h0002);
    send_cost(16'h0003);
    wait_drained();
  endtask

  task automatic test_large_sides();
    write_side(15);
    send_matrix(8, 0);
    wait_drained();
    write_side(8);
    send_matrix(8, 0);
    wait_drained();
    write_side(7);
    send_matrix(7, 0);
    wait_drained();
  endtask

  task automatic test_random_phase(input int unsigned sidle, input int unsigned rstall);
    int unsigned sent;
    int unsigned n;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    sent = 0;
    while (sent < 30) begin
      n = $urandom_range(1, 5);
      write_side(n);
      send_matrix(n, (n <= 4 && $urandom_range(2) == 0) ? 1 : 0);
      sent += n * n;
      if ($urandom_range(9) == 0) begin
        // stray extra word: a whole matrix when n is 1, else a partial load discarded by the next side write
        send_cost($urandom_range(65535));
      end
      wait_drained();
    end
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk_i) begin
    assign_word_t w;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_assign_q.size() == 0) begin
        $display("%0t: unexpected word person=%0d job=%0d total=%0d last=%0d", $time,
                 person_index_o, assigned_job_o, total_cost_o, last_of_run_o);
        errors++;
      end else begin
        w = expected_assign_q.pop_front();
        if (person_index_o !== w.person || assigned_job_o !== w.job ||
            total_cost_o !== w.total || last_of_run_o !== w.last) begin
          $display("%0t: mismatch exp p=%0d j=%0d t=%0d l=%0d act p=%0d j=%0d t=%0d l=%0d",
                   $time, w.person, w.job, w.total, w.last, person_index_o,
                   assigned_job_o, total_cost_o, last_of_run_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_large_sides();
    test_random_phase(29, 75);
    test_random_phase(75, 29);
    test_random_phase(0, 0);
    wait_drained();
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
